FILE: hdl/mlt_pkg.sv
package mlt_pkg;

  // Field widths of the request and response items.
  localparam int KeyWidth    = 32;
  localparam int ClientWidth = 8;
  localparam int ModeWidth   = 2;
  localparam int StatusWidth = 3;

  // Request modes.
  localparam logic [ModeWidth-1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_RELEASE = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_DROP    = 2'd2;

  // Response status codes.
  localparam logic [StatusWidth-1:0] ST_OK           = 3'd0;
  localparam logic [StatusWidth-1:0] ST_UNIDENTIFIED = 3'd1;
  localparam logic [StatusWidth-1:0] ST_NO_LOCK      = 3'd2;
  localparam logic [StatusWidth-1:0] ST_NOT_OWNER    = 3'd3;
  localparam logic [StatusWidth-1:0] ST_TABLE_FULL   = 3'd4;

  typedef struct packed {
    logic [ModeWidth-1:0]   mode;
    logic [KeyWidth-1:0]    lock_key;
    logic [ClientWidth-1:0] client_id;
  } req_t;

  typedef struct packed {
    logic                   acquired;
    logic                   released;
    logic [StatusWidth-1:0] status;
  } rsp_t;

  // One table entry as it is kept in the entry memory.
  typedef struct packed {
    logic [KeyWidth-1:0]    key;
    logic                   owned;
    logic [ClientWidth-1:0] owner;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_e;

endpackage

FILE: hdl/mlt_ram.sv
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mutex_lock_table.sv
// A request scans the lock entries created so far; a hit for acquire or release ends the scan
// early, and an unidentified client or an unused mode skips the scan.
// Throughput: one request at a time; the scan reads one entry per cycle from the entry memory.
// Reset: asynchronous, active low; it empties the table (fill count to zero) and the output.
// No clearing pass is needed after reset, so a request is accepted in the first cycle.
module mutex_lock_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mlt_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mlt_pkg::rsp_t out_data_o
);

  import mlt_pkg::*;

  localparam int IdxWidth   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntWidth   = $clog2(TABLE_DEPTH + 1);
  localparam int EntryWidth = $bits(entry_t);

  // Entries are never removed and a new one always takes the lowest free
  // slot, so the used slots form a prefix of the table. A fill count thus
  // stands in for the per-entry used bits. The owned flag lives in the
  // entry memory next to the owner; it is written whenever an entry is
  // created, so no slot below the fill count ever holds stale data.
  state_e               state_q, state_d;
  logic [CntWidth-1:0]  count_q, count_d;
  logic [CntWidth-1:0]  rd_idx_q, rd_idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IdxWidth-1:0]  cmp_idx_q, cmp_idx_d;
  req_t                 req_q, req_d;
  rsp_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_data_q, out_data_d;

  logic                 ram_we;
  logic [IdxWidth-1:0]  ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [EntryWidth-1:0] ram_rdata;
  entry_t               ent;
  logic                 owner_match;
  logic                 key_match;

  mlt_ram #(
    .WIDTH (EntryWidth),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IdxWidth-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent         = entry_t'(ram_rdata);
  assign owner_match = ent.owned && (ent.owner == req_q.client_id);
  assign key_match   = ent.key == req_q.lock_key;

  // The scan is a two-stage pipeline: the read of entry i is issued while
  // the data of entry i-1 is compared. A hit for acquire or release ends the
  // scan at once; drop client walks every used entry and clears the owned
  // flag of each entry held by the client, writing behind the read pointer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = cmp_idx_q;
    ram_wdata   = ent;
    ram_re      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          rd_idx_d = '0;
          res_d    = '{acquired: 1'b0, released: 1'b0, status: ST_OK};
          if (in_data_i.client_id == '0) begin
            res_d.status = ST_UNIDENTIFIED;
            state_d      = S_EMIT;
          end else if (in_data_i.mode == MODE_ACQUIRE || in_data_i.mode == MODE_RELEASE ||
                       in_data_i.mode == MODE_DROP) begin
            state_d = S_SCAN;
          end else begin
            // The unused mode does nothing and answers with an all-zero item.
            state_d = S_EMIT;
          end
        end
      end

      S_SCAN: begin
        if (rd_idx_q < count_q) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + CntWidth'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IdxWidth-1:0];
        end

        if (cmp_vld_q) begin
          if (req_q.mode == MODE_DROP) begin
            if (owner_match) begin
              ram_we          = 1'b1;
              ram_wdata.owned = 1'b0;
            end
          end else if (key_match) begin
            cmp_vld_d = 1'b0;
            state_d   = S_EMIT;
            if (req_q.mode == MODE_ACQUIRE) begin
              // A held lock, even by the requester itself, is simply not granted.
              if (!ent.owned) begin
                ram_we          = 1'b1;
                ram_wdata.owned = 1'b1;
                ram_wdata.owner = req_q.client_id;
                res_d.acquired  = 1'b1;
              end
            end else if (owner_match) begin
              ram_we          = 1'b1;
              ram_wdata.owned = 1'b0;
              res_d.released  = 1'b1;
            end else begin
              res_d.status = ST_NOT_OWNER;
            end
          end
        end else if (rd_idx_q >= count_q) begin
          // Every used entry has been seen without a hit.
          state_d = S_EMIT;
          if (req_q.mode == MODE_ACQUIRE) begin
            if (count_q == CntWidth'(TABLE_DEPTH)) begin
              res_d.status = ST_TABLE_FULL;
            end else begin
              // Create the entry in the next free slot and grant it at once.
              ram_we          = 1'b1;
              ram_waddr       = count_q[IdxWidth-1:0];
              ram_wdata.key   = req_q.lock_key;
              ram_wdata.owned = 1'b1;
              ram_wdata.owner = req_q.client_id;
              count_d         = count_q + CntWidth'(1);
              res_d.acquired  = 1'b1;
            end
          end else if (req_q.mode == MODE_RELEASE) begin
            res_d.status = ST_NO_LOCK;
          end
        end
      end

      S_EMIT: begin
        // The output register frees up when its item is taken, so the result can move in
        // as the old item leaves; a new request is accepted only once the result has moved in.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    req_q      <= req_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(TABLE_DEPTH))
    else $error("fill count exceeds the table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CntWidth'(1)))
    else $error("fill count moved by more than one entry");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN))
    else $error("entry memory written outside a scan");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_EMIT))
    else $error("response appeared without a finished request");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.acquired || out_data_o.released)) |->
      (out_data_o.status == ST_OK && !(out_data_o.acquired && out_data_o.released)))
    else $error("grant flags inconsistent with status");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mlt_pkg::*;

  // Table size used for this run. It also sets how long the block may need per item.
  localparam int Depth = 64;

  // The mode value that carries no meaning. The block must answer it with a plain OK.
  localparam logic [ModeWidth-1:0] MODE_UNUSED = 2'd3;

  localparam int MaxIdle     = 17;      // longest per-item gap on either side
  localparam int RandomItems = 400;     // size of the random part
  localparam int PoolSize    = 80;      // more keys than slots, so the table fills up
  localparam int HoldAt      = 150;     // response count at which the receiver holds off
  localparam int HoldLen     = 250;     // length of that hold-off in cycles
  localparam int QuietLimit  = 2000;    // cycles without any item moving before giving up
  localparam int TailCycles  = Depth + 16;

  typedef struct {
    req_t rq;
    bit   drain;  // wait for every outstanding response before offering this item
  } pending_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_data_o;

  // Shadow copy of the lock table, kept in step with the block as requests are accepted.
  logic                   tbl_used  [Depth];
  logic [KeyWidth-1:0]    tbl_key   [Depth];
  logic                   tbl_owned [Depth];
  logic [ClientWidth-1:0] tbl_owner [Depth];

  pending_t            request_q[$];       // requests still to be offered
  rsp_t                lock_outcome_q[$];  // predicted responses, oldest first
  logic [KeyWidth-1:0] key_pool[PoolSize];

  int n_sent      = 0;  // requests accepted by the block
  int n_rcvd      = 0;  // responses taken from the block
  int n_errors    = 0;
  int quiet_cycles = 0;
  int tx_gap      = 0;
  int rx_wait     = 0;
  int rx_hold     = 0;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  bit drain_next  = 1'b0;

  mutex_lock_table #(
    .TABLE_DEPTH(Depth)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the response to one accepted request and applies its effect on the shadow
  // table. A lookup only ever touches keys in used slots and owners in owned slots, just as
  // the block must, so the unwritten contents of the table never matter.
  function automatic rsp_t lock_outcome(req_t rq);
    rsp_t r;
    int   slot;
    r    = '0;
    slot = -1;
    if (rq.client_id == '0) begin
      // An unidentified client is turned away whatever it asks for.
      r.status = ST_UNIDENTIFIED;
    end else if (rq.mode == MODE_ACQUIRE) begin
      for (int i = 0; i < Depth; i++) begin
        if (slot < 0 && tbl_used[i] && tbl_key[i] == rq.lock_key) slot = i;
      end
      if (slot < 0) begin
        // A new key takes the lowest free slot and starts out unowned.
        for (int i = 0; i < Depth; i++) begin
          if (slot < 0 && !tbl_used[i]) slot = i;
        end
        if (slot >= 0) begin
          tbl_used[slot]  = 1'b1;
          tbl_key[slot]   = rq.lock_key;
          tbl_owned[slot] = 1'b0;
        end
      end
      if (slot < 0) begin
        r.status = ST_TABLE_FULL;
      end else if (!tbl_owned[slot]) begin
        tbl_owned[slot] = 1'b1;
        tbl_owner[slot] = rq.client_id;
        r.acquired      = 1'b1;
      end
      // A lock that is already held, even by the requester, is refused with an OK status.
    end else if (rq.mode == MODE_RELEASE) begin
      for (int i = 0; i < Depth; i++) begin
        if (slot < 0 && tbl_used[i] && tbl_key[i] == rq.lock_key) slot = i;
      end
      if (slot < 0) begin
        r.status = ST_NO_LOCK;
      end else if (!tbl_owned[slot] || tbl_owner[slot] != rq.client_id) begin
        r.status = ST_NOT_OWNER;
      end else begin
        tbl_owned[slot] = 1'b0;
        r.released      = 1'b1;
      end
    end else if (rq.mode == MODE_DROP) begin
      // Dropping a client frees every lock it holds; the key field plays no part.
      for (int i = 0; i < Depth; i++) begin
        if (tbl_used[i] && tbl_owned[i] && tbl_owner[i] == rq.client_id) tbl_owned[i] = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic queue_request(logic [ModeWidth-1:0] mode, logic [KeyWidth-1:0] key,
                               logic [ClientWidth-1:0] client);
    pending_t p;
    p.rq.mode      = mode;
    p.rq.lock_key  = key;
    p.rq.client_id = client;
    p.drain        = drain_next;
    drain_next     = 1'b0;
    request_q.push_back(p);
  endtask

  // Mostly a handful of busy clients so that they contend for the same locks, now and then
  // the unidentified client, and now and then any client id at all.
  function automatic logic [ClientWidth-1:0] pick_client();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return ClientWidth'($urandom_range(1, 6));
    if (roll < 92) return '0;
    return ClientWidth'($urandom_range(0, 255));
  endfunction

  // Keys come mostly from a fixed pool, so that locks are met again; the rest are fresh.
  function automatic logic [KeyWidth-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, PoolSize - 1)];
    return KeyWidth'($urandom);
  endfunction

  // The driver offers the next pending item once its idle gap has run out. A stalled item
  // stays on the bus unchanged. Each accepted item is predicted right away, in order.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    pending_t nxt;
    bit       taken;
    int       gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap     <= 0;
      n_sent     <= 0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        lock_outcome_q.push_back(lock_outcome(in_data_i));
        n_sent <= n_sent + 1;
        // Every so often switch between back-to-back items and random gaps.
        if ($urandom_range(0, 29) == 0) tx_calm <= !tx_calm;
      end
      if (!in_valid_i || taken) begin
        if (taken) gap = tx_calm ? 0 : $urandom_range(0, MaxIdle);
        else gap = tx_gap;
        // An item marked for draining waits until the block has answered everything.
        if (gap != 0 || request_q.size() == 0 ||
            (request_q[0].drain && (taken || n_sent != n_rcvd))) begin
          in_valid_i <= 1'b0;
          tx_gap     <= (gap != 0) ? gap - 1 : 0;
        end else begin
          nxt = request_q.pop_front();
          in_data_i  <= nxt.rq;
          in_valid_i <= 1'b1;
          tx_gap     <= 0;
        end
      end
    end
  end

  // The monitor takes responses, checks them against the oldest prediction, and decides the
  // stall for the next cycle. Per-response waits only count down while a response is shown,
  // so each one really is held back. The long hold-off counts down on every cycle.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    rsp_t want;
    bit   taken;
    int   hold;
    int   wait_c;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait     <= 0;
      rx_hold     <= 0;
      n_rcvd      <= 0;
    end else begin
      taken  = out_valid_o && !out_stall_i;
      hold   = rx_hold;
      wait_c = rx_wait;
      if (taken) begin
        if (n_rcvd == n_sent) begin
          $error("response with no request outstanding: acquired=%0d released=%0d status=%0d",
                 out_data_o.acquired, out_data_o.released, out_data_o.status);
          n_errors++;
        end else begin
          want = lock_outcome_q.pop_front();
          if (out_data_o.acquired !== want.acquired) begin
            $error("acquired: expected %0d, got %0d", want.acquired, out_data_o.acquired);
            n_errors++;
          end
          if (out_data_o.released !== want.released) begin
            $error("released: expected %0d, got %0d", want.released, out_data_o.released);
            n_errors++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            n_errors++;
          end
          n_rcvd <= n_rcvd + 1;
          // Hold off once for a long stretch, so the block fills and stalls its input.
          if (n_rcvd + 1 == HoldAt) hold = HoldLen;
        end
        wait_c = rx_calm ? 0 : $urandom_range(0, MaxIdle);
        if ($urandom_range(0, 29) == 0) rx_calm <= !rx_calm;
      end else if (hold != 0) begin
        hold--;
      end else if (out_valid_o && wait_c != 0) begin
        wait_c--;
      end
      rx_hold     <= hold;
      rx_wait     <= wait_c;
      out_stall_i <= (hold != 0) || (wait_c != 0);
    end
  end

  // Watchdog: if no item moves on either side for too long, the block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus_proc
    logic [KeyWidth-1:0]    k;
    logic [ClientWidth-1:0] c;
    int                     roll;
    bit                     second_drain;
    second_drain = 1'b0;

    for (int i = 0; i < Depth; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_owned[i] = 1'b0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = KeyWidth'($urandom);

    // Directed part. The unidentified client is refused for every mode, mode three included.
    queue_request(MODE_ACQUIRE, 32'h0000_0000, 8'd0);
    queue_request(MODE_RELEASE, 32'hFFFF_FFFF, 8'd0);
    queue_request(MODE_DROP,    32'h1234_5678, 8'd0);
    queue_request(MODE_UNUSED,  32'h0000_0000, 8'd0);
    // Releasing a key that was never seen reports that there is no such lock.
    queue_request(MODE_RELEASE, 32'h0000_0000, 8'd1);
    // First acquire creates the entry and grants it; the owner's second try is refused,
    // and so is another client's attempt.
    queue_request(MODE_ACQUIRE, 32'h0000_0000, 8'd1);
    queue_request(MODE_ACQUIRE, 32'h0000_0000, 8'd1);
    queue_request(MODE_ACQUIRE, 32'h0000_0000, 8'd255);
    // A stranger cannot release it, the owner can, and then nobody owns it.
    queue_request(MODE_RELEASE, 32'h0000_0000, 8'd255);
    queue_request(MODE_RELEASE, 32'h0000_0000, 8'd1);
    queue_request(MODE_RELEASE, 32'h0000_0000, 8'd1);
    // One client takes three locks, including an existing unowned one, then is dropped.
    queue_request(MODE_ACQUIRE, 32'hFFFF_FFFF, 8'd255);
    queue_request(MODE_ACQUIRE, 32'h0000_0000, 8'd255);
    queue_request(MODE_ACQUIRE, 32'h5555_AAAA, 8'd255);
    queue_request(MODE_DROP,    32'hAAAA_5555, 8'd255);
    queue_request(MODE_RELEASE, 32'hFFFF_FFFF, 8'd255);
    queue_request(MODE_UNUSED,  32'hA5A5_A5A5, 8'd7);
    // Dropping a client that owns nothing leaves other owners alone.
    queue_request(MODE_ACQUIRE, 32'hFFFF_FFFF, 8'd2);
    queue_request(MODE_ACQUIRE, 32'h0000_0000, 8'd3);
    queue_request(MODE_DROP,    32'h0000_0000, 8'd9);
    queue_request(MODE_DROP,    32'hFFFF_FFFF, 8'd2);
    queue_request(MODE_RELEASE, 32'h0000_0000, 8'd3);

    // Random part. Most of it is acquire and release pairs on a shared key, with a second
    // client now and then poking at the same lock in between; the rest is loose noise over every field.
    // The sender drains the block before the first random item and again midway.
    drain_next = 1'b1;
    while (request_q.size() < RandomItems + 22) begin
      if (!second_drain && request_q.size() >= 250) begin
        drain_next   = 1'b1;
        second_drain = 1'b1;
      end
      if ($urandom_range(0, 9) < 6) begin
        k = pick_key();
        c = pick_client();
        queue_request(MODE_ACQUIRE, k, c);
        case ($urandom_range(0, 3))
          0:       queue_request(MODE_ACQUIRE, k, pick_client());
          1:       queue_request(MODE_RELEASE, k, pick_client());
          default: ;
        endcase
        roll = $urandom_range(0, 9);
        if (roll < 2) queue_request(MODE_DROP, KeyWidth'($urandom), c);
        else if (roll > 2) queue_request(MODE_RELEASE, k, c);
        // Otherwise the lock stays held for a while.
      end else begin
        queue_request(ModeWidth'($urandom_range(0, 3)), pick_key(), pick_client());
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is in and every response is out, then let the block settle.
    while (request_q.size() != 0 || in_valid_i || n_rcvd != n_sent) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (n_rcvd != n_sent) begin
      $error("%0d responses never arrived", n_sent - n_rcvd);
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mlt_pkg.sv
hdl/mlt_ram.sv
hdl/mutex_lock_table.sv
verif/tb_top.sv
